// ----- rtl/core/zokt_pkg.sv -----
package zokt_pkg;

	// Field widths of the item, the result and the capacity register.
	localparam int CAP_W   = 11;
	localparam int COST_W  = 11;
	localparam int WORTH_W = 16;
	localparam int VALUE_W = 32;

	// Default maximum capacity (the last table address) and reset value of the capacity register.
	localparam int MAX_CAPACITY_DEF = 1024;
	localparam logic [CAP_W-1:0] CAPACITY_RESET = 11'd1024;

	// Operation codes of an item.
	localparam logic OP_CLEAR = 1'b0;
	localparam logic OP_APPLY = 1'b1;

endpackage

// ----- rtl/core/zero_one_knapsack_table_top.sv -----
// 0/1 knapsack best-value table. An item with operation apply folds one object
// (cost, worth) into the table: every entry from the effective capacity down to
// the cost, one entry per cycle, becomes the larger of itself and the entry at
// budget minus cost plus worth, saturating at the top of the 32-bit range. An item
// with operation clear zeroes the table. Each item gives exactly one result, the
// entry at the effective capacity (capacity saturated at MAX_CAPACITY), on
// best_value for the single cycle in which done is high; the receiver cannot
// stall, so it must take the result in that cycle. An item is taken when start is
// high and busy is low. An apply then walks the scan, one entry a cycle through
// the single write port of the table, then a flush of the last write-back, a read
// of the reported entry and the report before busy falls; an apply whose cost
// exceeds the capacity goes straight to the read and the report, and a clear
// sweeps the whole table before them. After reset the block sweeps the table to
// zero with busy high. Write capacity only while busy is low.
module zero_one_knapsack_table_top import zokt_pkg::*; #(
	parameter int MAX_CAPACITY = MAX_CAPACITY_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic               operation,
	input  logic [COST_W-1:0]  cost,
	input  logic [WORTH_W-1:0] worth,
	input  logic               capacity_we,
	input  logic [CAP_W-1:0]   capacity,
	output logic               done,
	output logic [VALUE_W-1:0] best_value
);

	localparam int DEPTH = MAX_CAPACITY + 1;
	localparam int AW    = (DEPTH > 2) ? $clog2(DEPTH) : 1;

	logic               mem_we;
	logic [AW-1:0]      mem_waddr;
	logic [VALUE_W-1:0] mem_wdata;
	logic [AW-1:0]      mem_raddr_a;
	logic [AW-1:0]      mem_raddr_b;
	logic [VALUE_W-1:0] mem_rdata_a;
	logic [VALUE_W-1:0] mem_rdata_b;

	zokt_seq #(
		.MAX_CAPACITY(MAX_CAPACITY),
		.AW          (AW)
	) u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.operation  (operation),
		.cost       (cost),
		.worth      (worth),
		.capacity_we(capacity_we),
		.capacity   (capacity),
		.busy       (busy),
		.done       (done),
		.mem_we     (mem_we),
		.mem_waddr  (mem_waddr),
		.mem_wdata  (mem_wdata),
		.mem_raddr_a(mem_raddr_a),
		.mem_raddr_b(mem_raddr_b),
		.mem_rdata_a(mem_rdata_a),
		.mem_rdata_b(mem_rdata_b)
	);

	zokt_mem #(
		.DEPTH(DEPTH),
		.AW   (AW)
	) u_mem (
		.clk    (clk),
		.we     (mem_we),
		.waddr  (mem_waddr),
		.wdata  (mem_wdata),
		.raddr_a(mem_raddr_a),
		.raddr_b(mem_raddr_b),
		.rdata_a(mem_rdata_a),
		.rdata_b(mem_rdata_b)
	);

	zokt_sat_check u_check (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.busy  (busy),
		.done  (done)
	);

	// The reported entry comes straight from the registered read port.
	assign best_value = mem_rdata_a;

endmodule

// ----- rtl/core/zokt_mem.sv -----
module zokt_mem import zokt_pkg::*; #(
	parameter int DEPTH = MAX_CAPACITY_DEF + 1,
	parameter int AW    = $clog2(MAX_CAPACITY_DEF + 1)
) (
	input  logic               clk,
	input  logic               we,
	input  logic [AW-1:0]      waddr,
	input  logic [VALUE_W-1:0] wdata,
	input  logic [AW-1:0]      raddr_a,
	input  logic [AW-1:0]      raddr_b,
	output logic [VALUE_W-1:0] rdata_a,
	output logic [VALUE_W-1:0] rdata_b
);

	// Best-value table, one write port and two registered read ports.
	logic [VALUE_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_a <= mem[raddr_a];
		rdata_b <= mem[raddr_b];
	end

endmodule

// ----- rtl/core/zokt_seq.sv -----
module zokt_seq import zokt_pkg::*; #(
	parameter int MAX_CAPACITY = MAX_CAPACITY_DEF,
	parameter int AW           = $clog2(MAX_CAPACITY_DEF + 1)
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic               operation,
	input  logic [COST_W-1:0]  cost,
	input  logic [WORTH_W-1:0] worth,
	input  logic               capacity_we,
	input  logic [CAP_W-1:0]   capacity,
	output logic               busy,
	output logic               done,
	output logic               mem_we,
	output logic [AW-1:0]      mem_waddr,
	output logic [VALUE_W-1:0] mem_wdata,
	output logic [AW-1:0]      mem_raddr_a,
	output logic [AW-1:0]      mem_raddr_b,
	input  logic [VALUE_W-1:0] mem_rdata_a,
	input  logic [VALUE_W-1:0] mem_rdata_b
);

	typedef enum logic [5:0] {
		ST_IDLE   = 6'b000001,
		ST_CLEAR  = 6'b000010,
		ST_SCAN   = 6'b000100,
		ST_FLUSH  = 6'b001000,
		ST_READ   = 6'b010000,
		ST_REPORT = 6'b100000
	} seq_state_t;

	localparam logic [AW-1:0] LAST_ADDR = AW'(MAX_CAPACITY);

	seq_state_t         state_q;
	logic [AW-1:0]      idx_q;
	logic [AW-1:0]      cost_q;
	logic [AW-1:0]      cap_q;
	logic [WORTH_W-1:0] worth_q;
	logic [CAP_W-1:0]   capacity_q;
	logic               pend_q;
	logic               v_s1;
	logic [AW-1:0]      b_s1;

	logic               accept;
	logic [31:0]        cap_w;
	logic [AW-1:0]      cap_eff;
	logic               cost_fits;
	logic [VALUE_W:0]   sum;
	logic [VALUE_W-1:0] cand;
	logic [VALUE_W-1:0] upd;

	assign busy   = (state_q != ST_IDLE);
	assign done   = (state_q == ST_REPORT);
	assign accept = start && !busy;

	// Effective capacity saturates at MAX_CAPACITY, the last table address.
	assign cap_w     = 32'(capacity_q);
	assign cap_eff   = (cap_w > 32'(MAX_CAPACITY)) ? LAST_ADDR : AW'(cap_w);
	assign cost_fits = (32'(cost) <= 32'(cap_eff));

	// Candidate from the lower entry, saturating, then the larger of the two.
	assign sum  = {1'b0, mem_rdata_b} + (VALUE_W + 1)'(worth_q);
	assign cand = sum[VALUE_W] ? {VALUE_W{1'b1}} : sum[VALUE_W-1:0];
	assign upd  = (cand > mem_rdata_a) ? cand : mem_rdata_a;

	// Memory port drive: clearing sweep or write-back of the update stage.
	assign mem_we      = (state_q == ST_CLEAR) || v_s1;
	assign mem_waddr   = (state_q == ST_CLEAR) ? idx_q : b_s1;
	assign mem_wdata   = (state_q == ST_CLEAR) ? '0 : upd;
	assign mem_raddr_a = (state_q == ST_READ) ? cap_q : idx_q;
	assign mem_raddr_b = idx_q - cost_q;

	// Capacity register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= CAPACITY_RESET;
		end else if (capacity_we) begin
			capacity_q <= capacity;
		end
	end

	// Read-modify-write stage: data read in the previous cycle is written back now.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= (state_q == ST_SCAN);
		end
	end

	always_ff @(posedge clk) begin
		b_s1 <= idx_q;
	end

	// Sequencer: clearing sweep, descending scan, then read of the reported entry.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			idx_q   <= '0;
			pend_q  <= 1'b0;
			cost_q  <= '0;
			cap_q   <= '0;
			worth_q <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						pend_q  <= 1'b1;
						cap_q   <= cap_eff;
						worth_q <= worth;
						if (operation == OP_CLEAR) begin
							idx_q   <= '0;
							state_q <= ST_CLEAR;
						end else if (cost_fits) begin
							idx_q   <= cap_eff;
							cost_q  <= AW'(cost);
							state_q <= ST_SCAN;
						end else begin
							state_q <= ST_READ;
						end
					end
				end
				ST_CLEAR: begin
					idx_q <= idx_q + 1'b1;
					if (idx_q == LAST_ADDR) begin
						state_q <= pend_q ? ST_READ : ST_IDLE;
					end
				end
				ST_SCAN: begin
					if (idx_q == cost_q) begin
						state_q <= ST_FLUSH;
					end else begin
						idx_q <= idx_q - 1'b1;
					end
				end
				ST_FLUSH: begin
					state_q <= ST_READ;
				end
				ST_READ: begin
					state_q <= ST_REPORT;
				end
				ST_REPORT: begin
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// A write-back never lands below the object cost.
	assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 |-> (b_s1 >= cost_q))
		else $error("write-back below object cost");

	// The result strobe lasts one cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe longer than one cycle");

	// An accepted item makes the block busy.
	assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> busy)
		else $error("accepted item did not raise busy");

	// No table write is in flight while the block is idle.
	assert property (@(posedge clk) disable iff (!arst_n)
		!busy |-> !mem_we)
		else $error("table write while idle");

endmodule

// ----- rtl/core/zokt_mem_dummy_guard.sv -----
module zokt_sat_check import zokt_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic               busy,
	input  logic               done
);

	// Port-level checker: results only come from accepted work.
	logic work_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			work_q <= 1'b0;
		end else if (start && !busy) begin
			work_q <= 1'b1;
		end else if (done) begin
			work_q <= 1'b0;
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		done |-> work_q)
		else $error("result without an accepted item");

	assert property (@(posedge clk) disable iff (!arst_n)
		done |-> busy)
		else $error("result strobe while idle");

	assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> !work_q)
		else $error("item accepted while previous result pending");

endmodule

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 100ps

module tb_top;
	import zokt_pkg::*;

	localparam int TOP_BUDGET      = MAX_CAPACITY_DEF;
	localparam int STALL_LIMIT     = 20000;
	localparam int BUILDUP_REPEATS = 60;
	localparam int RANDOM_ITEMS    = 480;
	localparam int SMALL_BUDGET    = 48;

	logic               clk         = 1'b0;
	logic               arst_n      = 1'b0;
	logic               start       = 1'b0;
	logic               operation   = OP_CLEAR;
	logic [COST_W-1:0]  cost        = '0;
	logic [WORTH_W-1:0] worth       = '0;
	logic               capacity_we = 1'b0;
	logic [CAP_W-1:0]   capacity    = CAPACITY_RESET;
	logic               busy;
	logic               done;
	logic [VALUE_W-1:0] best_value;

	// Shadow copy of the best-value table and of the capacity register.
	logic [VALUE_W-1:0] best_tbl [0:TOP_BUDGET];
	logic [CAP_W-1:0]   budget_reg;
	logic [VALUE_W-1:0] pending_best [$];
	logic [VALUE_W-1:0] want_best;

	int errors       = 0;
	int items_sent   = 0;
	int clears_sent  = 0;
	int results_seen = 0;
	int cfg_writes   = 0;
	int idle_cycles  = 0;

	always #5 clk = ~clk;

	zero_one_knapsack_table_top dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.operation  (operation),
		.cost       (cost),
		.worth      (worth),
		.capacity_we(capacity_we),
		.capacity   (capacity),
		.done       (done),
		.best_value (best_value)
	);

	// Capacity as the block uses it: the register saturated at the last table address.
	function automatic int live_budget();
		return (budget_reg > TOP_BUDGET) ? TOP_BUDGET : int'(budget_reg);
	endfunction

	function automatic void wipe_table();
		for (int i = 0; i <= TOP_BUDGET; i++) begin
			best_tbl[i] = '0;
		end
	endfunction

	// Fold one item into the shadow table and return the value reported for it.
	function automatic logic [VALUE_W-1:0] fold_item(input logic op,
			input logic [COST_W-1:0] c, input logic [WORTH_W-1:0] w);
		int top;
		int b;
		logic [VALUE_W:0] sum;
		top = live_budget();
		if (op == OP_CLEAR) begin
			wipe_table();
		end else if (int'(c) <= top) begin
			// Walk downward so the object is taken at most once.
			for (b = top; b >= int'(c); b--) begin
				sum = {1'b0, best_tbl[b - int'(c)]} + {{(VALUE_W + 1 - WORTH_W){1'b0}}, w};
				if (sum[VALUE_W]) begin
					sum = {1'b0, {VALUE_W{1'b1}}};
				end
				if (sum[VALUE_W-1:0] > best_tbl[b]) begin
					best_tbl[b] = sum[VALUE_W-1:0];
				end
			end
		end
		return best_tbl[top];
	endfunction

	// Drive one item, hold it until the block takes it, then record the expectation.
	task automatic send_item(input logic op, input logic [COST_W-1:0] c,
			input logic [WORTH_W-1:0] w, input int gap);
		bit taken;
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		operation <= op;
		cost      <= c;
		worth     <= w;
		start     <= 1'b1;
		taken = 1'b0;
		while (!taken) begin
			@(posedge clk);
			taken = !busy;
		end
		pending_best.push_back(fold_item(op, c, w));
		items_sent++;
		if (op == OP_CLEAR) begin
			clears_sent++;
		end
	endtask

	// Stop sending and wait until every result is in and the block is idle.
	task automatic settle();
		start <= 1'b0;
		do begin
			@(posedge clk);
		end while (pending_best.size() != 0 || busy);
	endtask

	task automatic write_budget(input logic [CAP_W-1:0] v);
		settle();
		capacity    <= v;
		capacity_we <= 1'b1;
		@(posedge clk);
		capacity_we <= 1'b0;
		budget_reg = v;
		cfg_writes++;
	endtask

	function automatic int pick_gap();
		return $urandom_range(0, 6);
	endfunction

	// Reset capacity: full and over-capacity costs, zero cost, repeated cost, clear.
	task automatic test_default_capacity();
		send_item(OP_APPLY, 11'd0, 16'd0, pick_gap());
		send_item(OP_APPLY, 11'd1024, 16'hFFFF, pick_gap());
		send_item(OP_APPLY, 11'd1025, 16'd5, pick_gap());
		send_item(OP_APPLY, 11'd2047, 16'hFFFF, pick_gap());
		send_item(OP_APPLY, 11'd512, 16'd100, pick_gap());
		send_item(OP_APPLY, 11'd512, 16'd200, pick_gap());
		send_item(OP_CLEAR, 11'd2047, 16'hFFFF, pick_gap());
	endtask

	// Register extremes: above the table size, zero and one.
	task automatic test_capacity_extremes();
		write_budget(11'd2047);
		send_item(OP_APPLY, 11'd1024, 16'd40000, pick_gap());
		send_item(OP_APPLY, 11'd1, 16'd3, pick_gap());
		write_budget(11'd0);
		send_item(OP_APPLY, 11'd0, 16'd9, pick_gap());
		send_item(OP_APPLY, 11'd1, 16'd5, pick_gap());
		send_item(OP_APPLY, 11'd0, 16'hFFFF, pick_gap());
		write_budget(11'd1);
		send_item(OP_APPLY, 11'd1, 16'd12, pick_gap());
		send_item(OP_CLEAR, 11'd0, 16'd0, pick_gap());
	endtask

	// Entries above a lowered capacity must survive untouched until it is raised.
	task automatic test_capacity_change();
		write_budget(11'd10);
		send_item(OP_APPLY, 11'd3, 16'd50, pick_gap());
		send_item(OP_APPLY, 11'd4, 16'd70, pick_gap());
		write_budget(11'd20);
		send_item(OP_APPLY, 11'd5, 16'd30, pick_gap());
		write_budget(11'd7);
		send_item(OP_APPLY, 11'd2, 16'd15, pick_gap());
		write_budget(11'd20);
		send_item(OP_APPLY, 11'd21, 16'd1, pick_gap());
	endtask

	// Build a large entry 0 with back-to-back zero-cost objects, then carry it into entry 1.
	task automatic test_value_buildup();
		write_budget(11'd0);
		send_item(OP_CLEAR, 11'd0, 16'd0, 0);
		repeat (BUILDUP_REPEATS) begin
			send_item(OP_APPLY, 11'd0, 16'hFFFF, 0);
		end
		write_budget(11'd1);
		send_item(OP_APPLY, 11'd1, 16'hFFFF, 0);
		send_item(OP_APPLY, 11'd0, 16'd1, 0);
		send_item(OP_CLEAR, 11'd0, 16'd0, 0);
	endtask

	// Random phases, each at its own capacity; mostly small tables to keep the run short.
	task automatic test_random_mix();
		int sent;
		int sel;
		int phase_items;
		int top;
		bit eager;
		logic [CAP_W-1:0] budget;
		logic op;
		logic [COST_W-1:0] c;
		logic [WORTH_W-1:0] w;
		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			sel = $urandom_range(0, 9);
			if (sel == 0) begin
				budget = CAP_W'($urandom_range(TOP_BUDGET + 1, 2047));
			end else if (sel == 1) begin
				budget = CAP_W'(TOP_BUDGET);
			end else if (sel == 2) begin
				budget = CAP_W'($urandom_range(SMALL_BUDGET + 1, TOP_BUDGET - 1));
			end else begin
				budget = CAP_W'($urandom_range(0, SMALL_BUDGET));
			end
			write_budget(budget);
			top = live_budget();
			phase_items = (top > SMALL_BUDGET) ? $urandom_range(3, 8) : $urandom_range(20, 50);
			eager = ($urandom_range(0, 3) == 0);
			repeat (phase_items) begin
				op = ($urandom_range(0, 24) == 0) ? OP_CLEAR : OP_APPLY;
				sel = $urandom_range(0, 9);
				if (sel == 0) begin
					c = COST_W'($urandom_range(0, 2047));
				end else if (sel == 1) begin
					c = '0;
				end else begin
					c = COST_W'($urandom_range(0, top));
				end
				sel = $urandom_range(0, 9);
				if (sel == 0) begin
					w = 16'hFFFF;
				end else if (sel == 1) begin
					w = WORTH_W'($urandom_range(0, 15));
				end else begin
					w = WORTH_W'($urandom_range(0, 65535));
				end
				send_item(op, c, w, eager ? 0 : pick_gap());
				sent++;
			end
		end
	endtask

	// Compare each result with the oldest expectation.
	always @(posedge clk) begin
		if (arst_n && done) begin
			results_seen++;
			if (pending_best.size() == 0) begin
				errors++;
				$display("%0t ns: best_value with no item outstanding, expected none, actual %0d",
					$time, best_value);
			end else begin
				want_best = pending_best.pop_front();
				if (best_value !== want_best) begin
					errors++;
					$display("%0t ns: best_value mismatch, expected %0d, actual %0d",
						$time, want_best, best_value);
				end
			end
		end
	end

	// Watchdog on stretches with no handshake of any kind.
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done || capacity_we) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= STALL_LIMIT) begin
			$display("%0t ns: no progress for %0d cycles", $time, STALL_LIMIT);
			$display("tb_top: done, errors");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		wipe_table();
		budget_reg = CAPACITY_RESET;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		test_default_capacity();
		test_capacity_extremes();
		test_capacity_change();
		test_value_buildup();
		test_random_mix();
		settle();
		repeat (20) @(posedge clk);
		$display("Covered %0d items (%0d clears), %0d results, %0d capacity writes,",
			items_sent, clears_sent, results_seen, cfg_writes);
		$display("with large accumulated values and capacities from zero to above the table size.");
		if (errors == 0) begin
			$display("tb_top: done, clean");
		end else begin
			$display("tb_top: done, errors");
		end
		$finish;
	end

endmodule
